// ===== rtl/acrr_pkg.sv =====
// Shared constants, beat types and the slot-to-mux helper function of the ADC channel scanner.
`timescale 1ns / 1ps

package acrr_pkg;

   localparam int CHANNEL_SLOTS = 11;
   localparam int SAMPLE_BITS   = 10;

   localparam int MODE_BITS     = 1;
   localparam int SAMPLE_W      = 10;
   localparam int CHANNEL_W     = 4;
   localparam int READ_W        = 10;
   localparam int MUX_W         = 4;
   localparam int MASK_W        = 11;

   localparam int SLOT_BITS     = 4;
   localparam int SCAN_BITS     = SLOT_BITS + 1;

   localparam int REQ_TDATA_W   = 16;
   localparam int RSP_TDATA_W   = 16;

   localparam logic [MASK_W-1:0]    ENABLE_RESET  = 11'h7FF;
   localparam logic [MASK_W-1:0]    SLOT_MASK_ALL = MASK_W'((1 << CHANNEL_SLOTS) - 1);
   localparam logic [SLOT_BITS-1:0] SLOT_REF      = 4'd9;
   localparam logic [SLOT_BITS-1:0] SLOT_GND      = 4'd10;
   localparam logic [MUX_W-1:0]     MUX_REF       = 4'd14;
   localparam logic [MUX_W-1:0]     MUX_GND       = 4'd15;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_CONVERT = 1'b0,
      MODE_READ    = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic [SAMPLE_W-1:0]    sample;
      logic [CHANNEL_W-1:0]   channel;
   } req_item_type;

   typedef struct packed {
      logic [READ_W-1:0]      read_value;
      logic                   known_channel;
      logic [MUX_W-1:0]       next_mux;
   } rsp_item_type;

   function automatic logic [MUX_W-1:0] mux_code(input logic [SLOT_BITS-1:0] slot);
      logic [MUX_W-1:0] code;
      begin
         if (slot == SLOT_REF) begin
            code = MUX_REF;
         end else if (slot == SLOT_GND) begin
            code = MUX_GND;
         end else begin
            code = MUX_W'(slot);
         end
         return code;
      end
   endfunction

endpackage

// ===== rtl/acrr_scan_core.sv =====
// Scan state, result store, next-enabled-slot search and result formation.
`timescale 1ns / 1ps

module acrr_scan_core
   import acrr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [MASK_W-1:0]    csr_wr_data,
   input  logic                 fire,
   input  req_item_type         item,
   output rsp_item_type         result
);

   logic [MASK_W-1:0]      enable_mask_ff;
   logic [SLOT_BITS-1:0]   current_slot_ff;
   logic [SLOT_BITS-1:0]   current_slot_in;
   logic [SAMPLE_BITS-1:0] store_ff [CHANNEL_SLOTS];
   logic [MASK_W-1:0]      active;
   logic [SLOT_BITS-1:0]   found_slot;
   logic                   do_convert;
   logic                   do_write;
   logic                   known;

   assign active = enable_mask_ff & SLOT_MASK_ALL;

   always_comb begin
      logic [SCAN_BITS-1:0] cand;
      found_slot = current_slot_ff;
      for (int k = CHANNEL_SLOTS; k >= 1; k--) begin
         cand = SCAN_BITS'(current_slot_ff) + SCAN_BITS'(k);
         if (cand >= SCAN_BITS'(CHANNEL_SLOTS)) begin
            cand = cand - SCAN_BITS'(CHANNEL_SLOTS);
         end
         if (active[cand[SLOT_BITS-1:0]]) begin
            found_slot = cand[SLOT_BITS-1:0];
         end
      end
   end

   assign do_convert = fire && (item.mode == MODE_CONVERT) && (active != '0);
   assign do_write   = do_convert && (SCAN_BITS'(current_slot_ff) < SCAN_BITS'(CHANNEL_SLOTS));
   assign current_slot_in = do_convert ? found_slot : current_slot_ff;
   assign known = (item.mode == MODE_READ) &&
                  (SCAN_BITS'(item.channel) < SCAN_BITS'(CHANNEL_SLOTS));

   always_comb begin
      result.read_value    = '0;
      result.known_channel = known;
      result.next_mux      = mux_code(current_slot_in);
      if (known) begin
         result.read_value = READ_W'(store_ff[item.channel[SLOT_BITS-1:0]]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff  <= ENABLE_RESET;
         current_slot_ff <= '0;
         for (int s = 0; s < CHANNEL_SLOTS; s++) begin
            store_ff[s] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            enable_mask_ff <= csr_wr_data;
         end
         current_slot_ff <= current_slot_in;
         if (do_write) begin
            store_ff[current_slot_ff] <= SAMPLE_BITS'(item.sample);
         end
      end
   end

endmodule

// ===== rtl/adc_round_robin_channel_scanner.sv =====
// Top level of the ADC round-robin channel scanner: input and result registers.
//
//   channel  dir  tdata (low bit up)                      tuser
//   req_     in   sample[9:0], channel[13:10], pad        mode
//   rsp_     out  read_value[9:0], next_mux[13:10], pad   known_channel
//   csr_     in   enable_mask[10:0] on csr_wr_data         -
//
// One beat a cycle sustained while rsp_tready is high.
// The slot search and store update sit between the input and result registers.
// Reset clears the store, selects slot 0 and enables all eleven slots.
// A stalled result holds in its register; the input register keeps taking beats
// as long as the result register drains.
`timescale 1ns / 1ps

module adc_round_robin_channel_scanner
   import acrr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_TDATA_W-1:0]  req_tdata,   // sample[9:0], channel[13:10], zero pad
   input  logic                    req_tuser,   // mode
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,   // read_value[9:0], next_mux[13:10], zero pad
   output logic                    rsp_tuser,   // known_channel
   input  logic                    csr_wr_en,
   input  logic [MASK_W-1:0]       csr_wr_data
);

   logic          in_valid_ff;
   req_item_type  in_item_ff;
   req_item_type  in_item_in;
   logic          out_valid_ff;
   rsp_item_type  out_item_ff;
   rsp_item_type  core_result;
   logic          advance;
   logic          take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      in_item_in.mode    = mode_type'(req_tuser);
      in_item_in.sample  = req_tdata[SAMPLE_W-1:0];
      in_item_in.channel = req_tdata[SAMPLE_W+CHANNEL_W-1:SAMPLE_W];
   end

   acrr_scan_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (advance),
      .item        (in_item_ff),
      .result      (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.known_channel;
   assign rsp_tdata  = {(RSP_TDATA_W - READ_W - MUX_W)'(0), out_item_ff.next_mux,
                        out_item_ff.read_value};

endmodule
